// ----- rtl/fdcd_pkg.sv -----
// Package for the frame difference cut detector.
// Holds field widths, register indexes, the back end state type and the queue record.
// No dependencies.
package fdcd_pkg;

  localparam int BYTE_W         = 8;
  localparam int SUM_W          = 31;
  localparam int FRAME_W        = 32;
  localparam int SHOT_W         = 16;
  localparam int THRESH_W       = 8;
  localparam int BPF_W          = 24;
  localparam int CLAMP_W        = BPF_W + 1;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 24;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_FRAME_BYTES_DEF = 8388608;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_FRAME = CFG_IDX_W'(1);

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = THRESH_W'(60);
  localparam logic [BPF_W-1:0]    BPF_RESET       = BPF_W'(65536);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAT,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    logic             push;
    logic [SUM_W-1:0] sum;
  } frame_push_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic [SUM_W-1:0] sum;
  } queue_status_t;

endpackage

// ----- rtl/fdcd_if.sv -----
// Channel interfaces of the frame difference cut detector: input, result and configuration.
// Depends on fdcd_pkg for field widths.
interface fdcd_in_if;
  logic                            valid;
  logic                            ready;
  logic [fdcd_pkg::BYTE_W-1:0]     current_byte;
  logic [fdcd_pkg::BYTE_W-1:0]     previous_byte;
  logic                            end_of_frame;
  modport source (output valid, current_byte, previous_byte, end_of_frame, input ready);
  modport sink (input valid, current_byte, previous_byte, end_of_frame, output ready);
endinterface

interface fdcd_out_if;
  logic                            valid;
  logic                            ready;
  logic [fdcd_pkg::FRAME_W-1:0]    frame_index;
  logic [fdcd_pkg::BYTE_W-1:0]     mean_score;
  logic [fdcd_pkg::BYTE_W-1:0]     score_change;
  logic                            cut_found;
  logic [fdcd_pkg::SHOT_W-1:0]     current_shot;
  logic [fdcd_pkg::FRAME_W-1:0]    closed_length;
  modport source (output valid, frame_index, mean_score, score_change, cut_found,
                  current_shot, closed_length, input ready);
  modport sink (input valid, frame_index, mean_score, score_change, cut_found,
                current_shot, closed_length, output ready);
endinterface

interface fdcd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fdcd_pkg::CFG_IDX_W-1:0]    index;
  logic [fdcd_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/fdcd_front.sv -----
// Front end: takes byte pairs, accumulates the saturating difference sum per frame.
// Pushes the frame sum into the queue at end of frame. Depends on fdcd_pkg.
module fdcd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fdcd_pkg::BYTE_W-1:0]   current_byte,
  input  logic [fdcd_pkg::BYTE_W-1:0]   previous_byte,
  input  logic                          end_of_frame,
  input  logic                          queue_full,
  output fdcd_pkg::frame_push_t         push_o
);

  logic [fdcd_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [fdcd_pkg::BYTE_W-1:0] diff;
  logic [fdcd_pkg::SUM_W:0]    sum_wide;
  logic [fdcd_pkg::SUM_W-1:0]  sum_sat;
  logic                        accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign diff     = (current_byte > previous_byte) ? (current_byte - previous_byte)
                                                   : (previous_byte - current_byte);

  always_comb begin
    sum_wide = {1'b0, sum_r} + (fdcd_pkg::SUM_W + 1)'(diff);
    sum_sat  = sum_wide[fdcd_pkg::SUM_W] ? fdcd_pkg::SUM_MAX : sum_wide[fdcd_pkg::SUM_W-1:0];
    sum_nxt  = sum_r;
    if (accept) begin
      sum_nxt = end_of_frame ? '0 : sum_sat;
    end
    push_o.push = accept && end_of_frame;
    push_o.sum  = sum_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

endmodule

// ----- rtl/fdcd_queue.sv -----
// Short queue of frame sums between the front end and the divider back end.
// Depends on fdcd_pkg.
module fdcd_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fdcd_pkg::frame_push_t   push_i,
  input  logic                    pop,
  output fdcd_pkg::queue_status_t status_o
);

  logic [fdcd_pkg::SUM_W-1:0]       mem [fdcd_pkg::QUEUE_DEPTH];
  logic [fdcd_pkg::QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [fdcd_pkg::QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                             do_push, do_pop;

  assign status_o.empty = (count_r == '0);
  assign status_o.full  = (count_r == fdcd_pkg::QUEUE_CNT_W'(fdcd_pkg::QUEUE_DEPTH));
  assign status_o.sum   = mem[rd_ptr_r];
  assign do_push        = push_i.push && !status_o.full;
  assign do_pop         = pop && !status_o.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_i.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/fdcd_back.sv -----
// Back end: divides each frame sum by the clamped byte count one quotient bit per cycle,
// then scores the frame, tracks shots and holds the result. Depends on fdcd_pkg.
module fdcd_back #(
  parameter int MAX_FRAME_BYTES = fdcd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fdcd_pkg::queue_status_t         status_i,
  output logic                            pop,
  input  logic [fdcd_pkg::THRESH_W-1:0]   threshold,
  input  logic [fdcd_pkg::BPF_W-1:0]      bytes_per_frame,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fdcd_pkg::FRAME_W-1:0]    frame_index,
  output logic [fdcd_pkg::BYTE_W-1:0]     mean_score,
  output logic [fdcd_pkg::BYTE_W-1:0]     score_change,
  output logic                            cut_found,
  output logic [fdcd_pkg::SHOT_W-1:0]     current_shot,
  output logic [fdcd_pkg::FRAME_W-1:0]    closed_length
);

  localparam int DIV_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int SHD_W = DIV_W + fdcd_pkg::BYTE_W;
  localparam int CMP_W = (SHD_W > fdcd_pkg::SUM_W) ? SHD_W : fdcd_pkg::SUM_W;
  localparam logic [fdcd_pkg::CLAMP_W-1:0] MAX_BYTES = fdcd_pkg::CLAMP_W'(MAX_FRAME_BYTES);

  fdcd_pkg::back_state_t state_r, state_nxt;

  logic [fdcd_pkg::SUM_W-1:0]   rem_r;
  logic [fdcd_pkg::BYTE_W-1:0]  quo_r;
  logic [2:0]                   step_r;
  logic [DIV_W-1:0]             divisor_r;
  logic [fdcd_pkg::BYTE_W-1:0]  last_score_r;
  logic [fdcd_pkg::FRAME_W-1:0] frame_cnt_r;
  logic [fdcd_pkg::SHOT_W-1:0]  shot_r;
  logic [fdcd_pkg::FRAME_W-1:0] shot_first_r;
  logic [fdcd_pkg::FRAME_W-1:0] frame_index_r;
  logic [fdcd_pkg::BYTE_W-1:0]  mean_score_r;
  logic [fdcd_pkg::BYTE_W-1:0]  score_change_r;
  logic                         cut_found_r;
  logic [fdcd_pkg::SHOT_W-1:0]  current_shot_r;
  logic [fdcd_pkg::FRAME_W-1:0] closed_length_r;

  logic [fdcd_pkg::CLAMP_W-1:0] clamp_wide;
  logic [CMP_W-1:0]             rem_ext, sat_bound, cand;
  logic                         sat_hit, step_hit;
  logic [fdcd_pkg::BYTE_W-1:0]  change;
  logic                         cut;
  logic [fdcd_pkg::FRAME_W-1:0] frame_next;
  logic                         load_div, do_sat, do_step, do_fin;

  always_comb begin
    if (bytes_per_frame == '0) begin
      clamp_wide = fdcd_pkg::CLAMP_W'(1);
    end else if ({1'b0, bytes_per_frame} > MAX_BYTES) begin
      clamp_wide = MAX_BYTES;
    end else begin
      clamp_wide = {1'b0, bytes_per_frame};
    end
  end

  assign rem_ext    = CMP_W'(rem_r);
  assign sat_bound  = CMP_W'(divisor_r) << fdcd_pkg::BYTE_W;
  assign cand       = CMP_W'(divisor_r) << step_r;
  assign sat_hit    = rem_ext >= sat_bound;
  assign step_hit   = rem_ext >= cand;
  assign change     = (quo_r > last_score_r) ? (quo_r - last_score_r) : (last_score_r - quo_r);
  assign cut        = (change > threshold) && (quo_r > threshold);
  assign frame_next = frame_cnt_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fdcd_pkg::ST_IDLE: if (!status_i.empty) state_nxt = fdcd_pkg::ST_SAT;
      fdcd_pkg::ST_SAT:  state_nxt = sat_hit ? fdcd_pkg::ST_FIN : fdcd_pkg::ST_DIV;
      fdcd_pkg::ST_DIV:  if (step_r == '0) state_nxt = fdcd_pkg::ST_FIN;
      fdcd_pkg::ST_FIN:  state_nxt = fdcd_pkg::ST_OUT;
      fdcd_pkg::ST_OUT:  if (out_ready) state_nxt = fdcd_pkg::ST_IDLE;
      default:           state_nxt = fdcd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    load_div  = 1'b0;
    do_sat    = 1'b0;
    do_step   = 1'b0;
    do_fin    = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      fdcd_pkg::ST_IDLE: load_div  = !status_i.empty;
      fdcd_pkg::ST_SAT:  do_sat    = 1'b1;
      fdcd_pkg::ST_DIV:  do_step   = 1'b1;
      fdcd_pkg::ST_FIN:  do_fin    = 1'b1;
      fdcd_pkg::ST_OUT:  out_valid = 1'b1;
      default:           out_valid = 1'b0;
    endcase
  end

  assign pop = load_div;

  always_ff @(posedge clk) begin
    if (load_div) begin
      rem_r     <= status_i.sum;
      divisor_r <= clamp_wide[DIV_W-1:0];
    end
    if (do_sat) begin
      quo_r  <= sat_hit ? {fdcd_pkg::BYTE_W{1'b1}} : '0;
      step_r <= 3'd7;
    end
    if (do_step) begin
      if (step_hit) begin
        rem_r         <= fdcd_pkg::SUM_W'(rem_ext - cand);
        quo_r[step_r] <= 1'b1;
      end
      step_r <= step_r - 1'b1;
    end
    if (do_fin) begin
      frame_index_r   <= frame_next;
      mean_score_r    <= quo_r;
      score_change_r  <= change;
      cut_found_r     <= cut;
      current_shot_r  <= cut ? shot_r + 1'b1 : shot_r;
      closed_length_r <= cut ? frame_next - shot_first_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fdcd_pkg::ST_IDLE;
      last_score_r <= '0;
      frame_cnt_r  <= fdcd_pkg::FRAME_W'(1);
      shot_r       <= '0;
      shot_first_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (do_fin) begin
        last_score_r <= quo_r;
        frame_cnt_r  <= frame_next;
        if (cut) begin
          shot_r       <= shot_r + 1'b1;
          shot_first_r <= frame_next;
        end
      end
    end
  end

  assign frame_index   = frame_index_r;
  assign mean_score    = mean_score_r;
  assign score_change  = score_change_r;
  assign cut_found     = cut_found_r;
  assign current_shot  = current_shot_r;
  assign closed_length = closed_length_r;

endmodule

// ----- rtl/frame_difference_cut_detector.sv -----
// Top level of the frame difference cut detector: configuration registers, front end,
// frame sum queue and divider back end. Depends on fdcd_pkg, fdcd_if and the fdcd modules.
//
// The input channel takes one byte pair per transfer, one per cycle while the frame sum
// queue has room. The transfer that carries end_of_frame closes the frame; each such frame
// yields one result transfer on the output channel, other transfers yield none.
// The back end divides the frame sum by the clamped byte count one quotient bit per cycle:
// it pops the sum when idle, checks for a saturated score, runs the divide steps unless
// the score saturates, registers the result and then presents it. It pops the next frame
// sum only after the receiver has taken the result. Up to four closed frames wait in the
// queue, so input keeps flowing while a result is held or divided; the input stalls only
// when the queue is full. A stalled receiver holds the result stable and stops the back
// end. Reset clears the sum, shot counter and queue, sets the frame counter to one and
// loads threshold 60 and 65536 bytes per frame. Configuration writes are always taken;
// they belong in idle periods.
module frame_difference_cut_detector #(
  parameter int MAX_FRAME_BYTES = fdcd_pkg::MAX_FRAME_BYTES_DEF
) (
  input logic            clk,
  input logic            rst_n,
  fdcd_in_if.sink        in_ch,
  fdcd_out_if.source     out_ch,
  fdcd_cfg_if.sink       cfg_ch
);

  logic [fdcd_pkg::THRESH_W-1:0] threshold_r;
  logic [fdcd_pkg::BPF_W-1:0]    bytes_per_frame_r;
  fdcd_pkg::frame_push_t         push;
  fdcd_pkg::queue_status_t       status;
  logic                          pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r       <= fdcd_pkg::THRESHOLD_RESET;
      bytes_per_frame_r <= fdcd_pkg::BPF_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        fdcd_pkg::REG_THRESHOLD:       threshold_r <= cfg_ch.data[fdcd_pkg::THRESH_W-1:0];
        fdcd_pkg::REG_BYTES_PER_FRAME: bytes_per_frame_r <= cfg_ch.data[fdcd_pkg::BPF_W-1:0];
        default: ;
      endcase
    end
  end

  fdcd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .current_byte  (in_ch.current_byte),
    .previous_byte (in_ch.previous_byte),
    .end_of_frame  (in_ch.end_of_frame),
    .queue_full    (status.full),
    .push_o        (push)
  );

  fdcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .pop      (pop),
    .status_o (status)
  );

  fdcd_back #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .status_i        (status),
    .pop             (pop),
    .threshold       (threshold_r),
    .bytes_per_frame (bytes_per_frame_r),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .frame_index     (out_ch.frame_index),
    .mean_score      (out_ch.mean_score),
    .score_change    (out_ch.score_change),
    .cut_found       (out_ch.cut_found),
    .current_shot    (out_ch.current_shot),
    .closed_length   (out_ch.closed_length)
  );

endmodule

// ----- rtl/fdcd_checker.sv -----
// Port-level checker for the frame difference cut detector, bound to the top level.
// Depends on fdcd_pkg for widths.
module fdcd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fdcd_pkg::FRAME_W-1:0]  frame_index,
  input logic [fdcd_pkg::BYTE_W-1:0]   mean_score,
  input logic [fdcd_pkg::BYTE_W-1:0]   score_change,
  input logic                          cut_found,
  input logic [fdcd_pkg::FRAME_W-1:0]  closed_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frame_index) && $stable(cut_found))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_no_cut_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !cut_found |-> closed_length == '0)
    else $error("closed length without a cut");

  a_cut_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cut_found |-> mean_score != '0 && score_change != '0)
    else $error("cut with zero score or change");

endmodule

bind frame_difference_cut_detector fdcd_checker u_fdcd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .frame_index   (out_ch.frame_index),
  .mean_score    (out_ch.mean_score),
  .score_change  (out_ch.score_change),
  .cut_found     (out_ch.cut_found),
  .closed_length (out_ch.closed_length)
);

// ----- tb/sv/frame_difference_cut_detector_test.sv -----
// Testbench for frame_difference_cut_detector: directed and random byte streams with
// random idling on both channels, checked against a cycle-free shot tracker.
// Depends on fdcd_pkg, the fdcd channel interfaces and the detector RTL.
module frame_difference_cut_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT      = 600000;
  localparam int          IDLE_SETTLE      = 16;
  localparam int          RANDOM_PHASES    = 12;
  localparam int          ITEMS_PER_PHASE  = 120;
  localparam int          LONG_FRAME_BYTES = 40;
  localparam int          MAX_REPORTS      = 10;
  localparam int unsigned DIVISOR_MAX      = fdcd_pkg::MAX_FRAME_BYTES_DEF;

  localparam logic [fdcd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = fdcd_pkg::CFG_IDX_W'(2);
  localparam logic [fdcd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = fdcd_pkg::CFG_IDX_W'(3);

  typedef struct packed {
    logic [fdcd_pkg::FRAME_W-1:0] frame_index;
    logic [fdcd_pkg::BYTE_W-1:0]  mean_score;
    logic [fdcd_pkg::BYTE_W-1:0]  score_change;
    logic                         cut_found;
    logic [fdcd_pkg::SHOT_W-1:0]  current_shot;
    logic [fdcd_pkg::FRAME_W-1:0] closed_length;
  } frame_result_t;

  typedef enum {FRAME_STILL, FRAME_NOISY, FRAME_FLASH} frame_kind_t;

  class shot_tracker;
    logic [fdcd_pkg::THRESH_W-1:0] threshold;
    logic [fdcd_pkg::BPF_W-1:0]    frame_bytes;
    logic [fdcd_pkg::SUM_W-1:0]    diff_sum;
    logic [fdcd_pkg::BYTE_W-1:0]   last_frame_score;
    logic [fdcd_pkg::FRAME_W-1:0]  frame_count;
    logic [fdcd_pkg::SHOT_W-1:0]   shot_id;
    logic [fdcd_pkg::FRAME_W-1:0]  shot_start;
    frame_result_t                 pending_frames[$];
    int                            errors;
    int                            frames_checked;
    int                            cuts_seen;

    function new();
      threshold        = fdcd_pkg::THRESHOLD_RESET;
      frame_bytes      = fdcd_pkg::BPF_RESET;
      diff_sum         = '0;
      last_frame_score = '0;
      frame_count      = fdcd_pkg::FRAME_W'(1);
      shot_id          = '0;
      shot_start       = '0;
      errors           = 0;
      frames_checked   = 0;
      cuts_seen        = 0;
    endfunction

    function void write_register(logic [fdcd_pkg::CFG_IDX_W-1:0] idx,
                                 logic [fdcd_pkg::CFG_DATA_W-1:0] data);
      if (idx == fdcd_pkg::REG_THRESHOLD) begin
        threshold = data[fdcd_pkg::THRESH_W-1:0];
      end else if (idx == fdcd_pkg::REG_BYTES_PER_FRAME) begin
        frame_bytes = data[fdcd_pkg::BPF_W-1:0];
      end
    endfunction

    function void take_bytes(logic [fdcd_pkg::BYTE_W-1:0] cur,
                             logic [fdcd_pkg::BYTE_W-1:0] prev, logic eof);
      logic [fdcd_pkg::BYTE_W-1:0] diff;
      logic [fdcd_pkg::SUM_W:0]    widened;
      int unsigned                 divisor;
      int unsigned                 quotient;
      logic [fdcd_pkg::BYTE_W-1:0] score;
      logic [fdcd_pkg::BYTE_W-1:0] change;
      frame_result_t               res;
      diff    = (cur > prev) ? cur - prev : prev - cur;
      widened = {1'b0, diff_sum} + (fdcd_pkg::SUM_W + 1)'(diff);
      diff_sum = (widened > {1'b0, fdcd_pkg::SUM_MAX}) ? fdcd_pkg::SUM_MAX
                                                       : widened[fdcd_pkg::SUM_W-1:0];
      if (!eof) begin
        return;
      end
      divisor = 32'(frame_bytes);
      if (divisor == 0) begin
        divisor = 1;
      end
      if (divisor > DIVISOR_MAX) begin
        divisor = DIVISOR_MAX;
      end
      quotient   = diff_sum / divisor;
      score      = (quotient > 255) ? fdcd_pkg::BYTE_W'(255)
                                    : quotient[fdcd_pkg::BYTE_W-1:0];
      change     = (score > last_frame_score) ? score - last_frame_score
                                              : last_frame_score - score;
      last_frame_score = score;
      diff_sum   = '0;
      frame_count++;
      res.frame_index   = frame_count;
      res.mean_score    = score;
      res.score_change  = change;
      res.cut_found     = (change > threshold) && (score > threshold);
      res.closed_length = '0;
      if (res.cut_found) begin
        res.closed_length = frame_count - shot_start;
        shot_start        = frame_count;
        shot_id++;
      end
      res.current_shot = shot_id;
      pending_frames.insert(pending_frames.size(), res);
    endfunction

    function void compare_frame(frame_result_t got);
      frame_result_t want;
      if (pending_frames.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("Unexpected result transfer: frame %0d", got.frame_index);
        end
        return;
      end
      want = pending_frames.pop_front();
      frames_checked++;
      if (got.cut_found === 1'b1) begin
        cuts_seen++;
      end
      if (got.frame_index !== want.frame_index || got.mean_score !== want.mean_score ||
          got.score_change !== want.score_change || got.cut_found !== want.cut_found ||
          got.current_shot !== want.current_shot ||
          got.closed_length !== want.closed_length) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("Mismatch expected: frame %0d score %0d change %0d cut %0d shot %0d len %0d",
                   want.frame_index, want.mean_score, want.score_change, want.cut_found,
                   want.current_shot, want.closed_length);
          $display("         actual:   frame %0d score %0d change %0d cut %0d shot %0d len %0d",
                   got.frame_index, got.mean_score, got.score_change, got.cut_found,
                   got.current_shot, got.closed_length);
        end
      end
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   bytes_sent = 0;
  int   cfg_writes = 0;
  bit   send_idle = 1'b1;
  bit   recv_idle = 1'b1;

  shot_tracker tracker = new();

  fdcd_in_if  in_ch();
  fdcd_out_if out_ch();
  fdcd_cfg_if cfg_ch();

  frame_difference_cut_detector dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d frame results outstanding",
             cycle_count, tracker.pending());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_byte(logic [fdcd_pkg::BYTE_W-1:0] cur,
                           logic [fdcd_pkg::BYTE_W-1:0] prev, logic eof);
    int gap;
    gap = send_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.current_byte  <= cur;
    in_ch.previous_byte <= prev;
    in_ch.end_of_frame  <= eof;
    do @(posedge clk); while (!in_ch.ready);
    tracker.take_bytes(cur, prev, eof);
    bytes_sent++;
  endtask

  task automatic send_frame(int len, frame_kind_t kind);
    logic [fdcd_pkg::BYTE_W-1:0] cur;
    logic [fdcd_pkg::BYTE_W-1:0] prev;
    for (int i = 0; i < len; i++) begin
      case (kind)
        FRAME_STILL: begin
          cur  = fdcd_pkg::BYTE_W'($urandom);
          prev = cur ^ fdcd_pkg::BYTE_W'($urandom_range(0, 3));
        end
        FRAME_FLASH: begin
          cur  = fdcd_pkg::BYTE_W'($urandom_range(192, 255));
          prev = fdcd_pkg::BYTE_W'($urandom_range(0, 63));
        end
        default: begin
          cur  = fdcd_pkg::BYTE_W'($urandom);
          prev = fdcd_pkg::BYTE_W'($urandom);
        end
      endcase
      send_byte(cur, prev, i == len - 1);
    end
  endtask

  // Holds off the sender until every frame result is back and the back end has gone quiet.
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [fdcd_pkg::CFG_IDX_W-1:0] idx,
                           logic [fdcd_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.write_register(idx, data);
    cfg_writes++;
  endtask

  task automatic close_config();
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : result_sink
    int            stall;
    frame_result_t got;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = recv_idle ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.frame_index   = out_ch.frame_index;
      got.mean_score    = out_ch.mean_score;
      got.score_change  = out_ch.score_change;
      got.cut_found     = out_ch.cut_found;
      got.current_shot  = out_ch.current_shot;
      got.closed_length = out_ch.closed_length;
      tracker.compare_frame(got);
    end
  end

  initial begin : stimulus
    int                               filled;
    int                               len;
    logic [fdcd_pkg::THRESH_W-1:0]    thr;
    logic [fdcd_pkg::CFG_DATA_W-1:0]  bpf;
    in_ch.valid         <= 1'b0;
    in_ch.current_byte  <= '0;
    in_ch.previous_byte <= '0;
    in_ch.end_of_frame  <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= fdcd_pkg::REG_THRESHOLD;
    cfg_ch.data         <= '0;
    rst_n               <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: large default divisor, so scores stay at zero.
    send_byte(8'hFF, 8'h00, 1'b1);
    send_byte(8'h00, 8'hFF, 1'b1);
    send_byte(8'h80, 8'h80, 1'b1);
    settle_idle();

    // Writes to unmapped indexes must be dropped; a zero divisor acts as one.
    write_reg(REG_UNMAPPED_LO, 24'h000005);
    write_reg(REG_UNMAPPED_HI, 24'hFFFFFF);
    write_reg(fdcd_pkg::REG_THRESHOLD, 24'hABCD0A);
    write_reg(fdcd_pkg::REG_BYTES_PER_FRAME, 24'h000000);
    close_config();
    send_byte(8'h00, 8'hFF, 1'b1);
    send_byte(8'hFF, 8'hFF, 1'b1);
    send_byte(8'hFF, 8'h00, 1'b0);
    send_byte(8'h00, 8'hFF, 1'b1);
    send_byte(8'h80, 8'h7F, 1'b1);
    settle_idle();

    write_reg(fdcd_pkg::REG_BYTES_PER_FRAME, 24'd3);
    close_config();
    send_byte(8'h0A, 8'h00, 1'b0);
    send_byte(8'h00, 8'h14, 1'b0);
    send_byte(8'h05, 8'h05, 1'b1);
    settle_idle();

    write_reg(fdcd_pkg::REG_THRESHOLD, 24'h0000FF);
    write_reg(fdcd_pkg::REG_BYTES_PER_FRAME, 24'd1);
    close_config();
    send_byte(8'hFF, 8'h00, 1'b1);
    send_byte(8'h00, 8'h00, 1'b1);
    send_byte(8'hFF, 8'h00, 1'b1);
    settle_idle();

    write_reg(fdcd_pkg::REG_THRESHOLD, 24'hFFFF00);
    close_config();
    send_byte(8'h01, 8'h00, 1'b1);
    send_byte(8'h00, 8'h01, 1'b1);
    send_byte(8'h00, 8'h00, 1'b1);
    settle_idle();

    write_reg(fdcd_pkg::REG_BYTES_PER_FRAME, fdcd_pkg::CFG_DATA_W'(DIVISOR_MAX));
    close_config();
    send_byte(8'hFF, 8'h00, 1'b1);
    settle_idle();

    // An oversized divisor is taken as the clamp limit.
    write_reg(fdcd_pkg::REG_BYTES_PER_FRAME, 24'hFFFFFF);
    close_config();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    for (int i = 0; i < LONG_FRAME_BYTES; i++) begin
      send_byte(8'hFF, 8'h00, i == LONG_FRAME_BYTES - 1);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_idle();
      case ($urandom_range(0, 5))
        0:       thr = '0;
        1:       thr = '1;
        default: thr = fdcd_pkg::THRESH_W'($urandom_range(0, 120));
      endcase
      case ($urandom_range(0, 9))
        0:       bpf = '0;
        1:       bpf = fdcd_pkg::CFG_DATA_W'(DIVISOR_MAX);
        2:       bpf = fdcd_pkg::CFG_DATA_W'($urandom_range(DIVISOR_MAX + 1, 24'hFFFFFF));
        default: bpf = fdcd_pkg::CFG_DATA_W'($urandom_range(1, 16));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                  fdcd_pkg::CFG_DATA_W'($urandom));
      end
      if ($urandom_range(0, 1)) begin
        write_reg(fdcd_pkg::REG_BYTES_PER_FRAME, bpf);
        write_reg(fdcd_pkg::REG_THRESHOLD,
                  {(fdcd_pkg::CFG_DATA_W - fdcd_pkg::THRESH_W)'($urandom), thr});
      end else begin
        write_reg(fdcd_pkg::REG_THRESHOLD,
                  {(fdcd_pkg::CFG_DATA_W - fdcd_pkg::THRESH_W)'($urandom), thr});
        if ($urandom_range(0, 3) != 0) begin
          write_reg(fdcd_pkg::REG_BYTES_PER_FRAME, bpf);
        end
      end
      close_config();
      send_idle = (phase % 4 != 3) && ($urandom_range(0, 3) != 0);
      recv_idle = (phase % 4 != 2) && ($urandom_range(0, 3) != 0);
      filled = 0;
      while (filled < ITEMS_PER_PHASE) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        send_frame(len, frame_kind_t'($urandom_range(0, 2)));
        filled += len;
      end
    end

    settle_idle();
    if (tracker.pending() != 0) begin
      $display("%0d frame results never arrived", tracker.pending());
      tracker.errors += tracker.pending();
    end
    $display("Run covered %0d byte transfers, %0d frame results (%0d cuts), %0d register writes.",
             bytes_sent, tracker.frames_checked, tracker.cuts_seen, cfg_writes);
    $display("Divisors included zero, one, the clamp limit and oversized; thresholds 0 and 255.");
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", tracker.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
